// ===== sv/button_press_calibration_sequencer_defines.svh =====
// Assertion macros shared by the sequencer RTL.
`ifndef BUTTON_PRESS_CALIBRATION_SEQUENCER_DEFINES_SVH
`define BUTTON_PRESS_CALIBRATION_SEQUENCER_DEFINES_SVH

// Checks a property on every rising edge of clk outside reset.
`define BPCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the antecedent implies the consequent in the same cycle.
`define BPCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the antecedent implies the consequent in the next cycle.
`define BPCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bpcs_pkg.sv =====
package bpcs_pkg;

    localparam int ADC_W        = 12;
    localparam int TICK_W       = 32;
    localparam int CFG_W        = 20;
    localparam int EVENT_W      = 4;
    localparam int MODE_W       = 2;
    localparam int ADDR_W       = 3;
    localparam int PDATA_W      = 32;
    localparam int ADC_BITS_DEF = 12;

    localparam logic [CFG_W-1:0] SHORT_LIMIT_RST = CFG_W'(1000);
    localparam logic [CFG_W-1:0] LONG_TIME_RST   = CFG_W'(5000);

    // Register index, taken from paddr bit 2.
    localparam logic REG_SHORT_LIMIT = 1'b0;
    localparam logic REG_LONG_TIME   = 1'b1;

    localparam logic [EVENT_W-1:0] EV_NONE        = 4'd0;
    localparam logic [EVENT_W-1:0] EV_PRESSED     = 4'd1;
    localparam logic [EVENT_W-1:0] EV_MEAN_SET    = 4'd2;
    localparam logic [EVENT_W-1:0] EV_MEAN_ERR    = 4'd3;
    localparam logic [EVENT_W-1:0] EV_NO_ACTION   = 4'd4;
    localparam logic [EVENT_W-1:0] EV_CAL_ENTERED = 4'd5;
    localparam logic [EVENT_W-1:0] EV_LOW_OK      = 4'd6;
    localparam logic [EVENT_W-1:0] EV_LOW_ERR     = 4'd7;
    localparam logic [EVENT_W-1:0] EV_CAL_DONE    = 4'd8;
    localparam logic [EVENT_W-1:0] EV_HIGH_ERR    = 4'd9;
    localparam logic [EVENT_W-1:0] EV_AFTER_LONG  = 4'd10;

    localparam logic [MODE_W-1:0] MODE_CODE_IDLE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_WAIT_LOW  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_WAIT_HIGH = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'b001,
        MODE_WAIT_LOW  = 3'b010,
        MODE_WAIT_HIGH = 3'b100
    } cal_mode_t;

    typedef struct packed {
        logic              last_level;
        logic [TICK_W-1:0] press_start;
        logic              long_fired;
        logic              action_done;
        cal_mode_t         cal_mode;
    } ctrl_t;

    localparam ctrl_t CTRL_RESET = '{
        last_level:  1'b1,
        press_start: '0,
        long_fired:  1'b0,
        action_done: 1'b0,
        cal_mode:    MODE_IDLE
    };

    typedef struct packed {
        logic [CFG_W-1:0] short_press_limit;
        logic [CFG_W-1:0] long_press_time;
    } cfg_t;

    typedef struct packed {
        logic              raw_level;
        logic              confirm_level;
        logic [TICK_W-1:0] now_ticks;
        logic [ADC_W-1:0]  adc_sample;
        logic              adc_ok;
    } poll_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [ADC_W-1:0]   captured_value;
        logic [ADC_W-1:0]   low_reference;
        logic [MODE_W-1:0]  mode;
    } result_t;

    function automatic logic [MODE_W-1:0] mode_code(input cal_mode_t m);
        logic [MODE_W-1:0] code;
        case (m)
            MODE_IDLE:      code = MODE_CODE_IDLE;
            MODE_WAIT_LOW:  code = MODE_CODE_WAIT_LOW;
            MODE_WAIT_HIGH: code = MODE_CODE_WAIT_HIGH;
            default:        code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/bpcs_step.sv =====
module bpcs_step
    import bpcs_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF,
    parameter int SAMPLE_W = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W
)
(
    input  ctrl_t               ctrl,
    input  logic [SAMPLE_W-1:0] low_capture,
    input  cfg_t                cfg,
    input  poll_t               item,
    output ctrl_t               ctrl_next,
    output logic [SAMPLE_W-1:0] low_capture_next,
    output result_t             res
);

    logic                level;
    logic [TICK_W-1:0]   release_dur;
    logic [TICK_W-1:0]   hold_dur;
    logic [SAMPLE_W-1:0] sample;
    logic [EVENT_W-1:0]  ev;
    logic [ADC_W-1:0]    cap;
    logic [ADC_W-1:0]    lowref;

    assign sample      = item.adc_sample[SAMPLE_W-1:0];
    // A level that differs from the stored one counts only if the late read agrees.
    assign level       = (item.raw_level != ctrl.last_level) ? item.confirm_level
                                                             : item.raw_level;
    assign release_dur = item.now_ticks - ctrl.press_start;

    always_comb
    begin
        ctrl_next        = ctrl;
        low_capture_next = low_capture;
        ev               = EV_NONE;
        cap              = '0;
        lowref           = '0;

        if (level != ctrl.last_level)
        begin
            if (!level)
            begin
                ctrl_next.press_start = item.now_ticks;
                ctrl_next.long_fired  = 1'b0;
                ctrl_next.action_done = 1'b0;
                ev                    = EV_PRESSED;
            end
            else if (ctrl.long_fired)
            begin
                // The release that ends the long press itself does nothing.
                ev = EV_AFTER_LONG;
            end
            else
            begin
                case (ctrl.cal_mode)
                    MODE_IDLE:
                    begin
                        if (!ctrl.action_done &&
                            (release_dur < TICK_W'(cfg.short_press_limit)))
                        begin
                            ev  = item.adc_ok ? EV_MEAN_SET : EV_MEAN_ERR;
                            cap = item.adc_ok ? ADC_W'(sample) : '0;
                            ctrl_next.action_done = 1'b1;
                        end
                        else
                        begin
                            ev = EV_NO_ACTION;
                        end
                    end
                    MODE_WAIT_LOW:
                    begin
                        if (!ctrl.action_done)
                        begin
                            if (item.adc_ok)
                            begin
                                low_capture_next   = sample;
                                ctrl_next.cal_mode = MODE_WAIT_HIGH;
                                ev                 = EV_LOW_OK;
                                cap                = ADC_W'(sample);
                            end
                            else
                            begin
                                ev = EV_LOW_ERR;
                            end
                            ctrl_next.action_done = 1'b1;
                        end
                        else
                        begin
                            ev = EV_NO_ACTION;
                        end
                    end
                    default:
                    begin
                        if (!ctrl.action_done)
                        begin
                            if (item.adc_ok)
                            begin
                                ev     = EV_CAL_DONE;
                                cap    = ADC_W'(sample);
                                lowref = ADC_W'(low_capture);
                            end
                            else
                            begin
                                ev = EV_HIGH_ERR;
                            end
                            ctrl_next.cal_mode    = MODE_IDLE;
                            ctrl_next.action_done = 1'b1;
                        end
                        else
                        begin
                            ev = EV_NO_ACTION;
                        end
                    end
                endcase
            end
            ctrl_next.last_level = level;
        end

        // The hold check sees the state after the edge handling above.
        hold_dur = item.now_ticks - ctrl_next.press_start;
        if (!level && !ctrl_next.long_fired && (ctrl_next.cal_mode == MODE_IDLE) &&
            (hold_dur >= TICK_W'(cfg.long_press_time)))
        begin
            ctrl_next.long_fired = 1'b1;
            ctrl_next.cal_mode   = MODE_WAIT_LOW;
            ev                   = EV_CAL_ENTERED;
            cap                  = '0;
            lowref               = '0;
        end
    end

    assign res.event_res      = ev;
    assign res.captured_value = cap;
    assign res.low_reference  = lowref;
    assign res.mode           = mode_code(ctrl_next.cal_mode);

endmodule

// ===== sv/button_press_calibration_sequencer.sv =====
// Button press and calibration sequencer.
// Input channel (in_valid/in_ready) carries one button poll per transaction:
// raw and confirming levels, a wrapping tick timestamp and one ADC sample.
// Output channel (out_valid/out_ready) returns exactly one result per poll:
// the event code, captured sample, low reference and the mode after the poll.
// An accepted poll waits in the input register; its result is loaded into the
// result register when that register is free or being emptied. One poll is
// accepted every cycle while the receiver does not stall; the state update is
// a single pass of logic between the two registers.
// When the receiver stalls, the result register holds, the input register
// fills, and in_ready drops until the result is taken; nothing is dropped.
// The APB port sets short_press_limit (0x0) and long_press_time (0x4); write
// them only while no poll is in flight.
// Reset clears both registers' valid flags, restores the register defaults
// (1000 and 5000 ticks), sets the button to released and the mode to idle.
`include "button_press_calibration_sequencer_defines.svh"

module button_press_calibration_sequencer
    import bpcs_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic                raw_level,
    input  logic                confirm_level,
    input  logic [TICK_W-1:0]   now_ticks,
    input  logic [ADC_W-1:0]    adc_sample,
    input  logic                adc_ok,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [EVENT_W-1:0]  event_res,
    output logic [ADC_W-1:0]    captured_value,
    output logic [ADC_W-1:0]    low_reference,
    output logic [MODE_W-1:0]   mode
);

    localparam int SAMPLE_W = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;

    cfg_t                cfg_reg;
    ctrl_t               ctrl_reg;
    ctrl_t               ctrl_next;
    logic [SAMPLE_W-1:0] low_capture_reg;
    logic [SAMPLE_W-1:0] low_capture_next;
    logic                s1_valid_reg;
    poll_t               s1_item_reg;
    logic                out_valid_reg;
    result_t             out_res_reg;
    result_t             res_next;
    logic                advance;
    logic                cfg_write;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_press_limit <= SHORT_LIMIT_RST;
            cfg_reg.long_press_time   <= LONG_TIME_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_SHORT_LIMIT: cfg_reg.short_press_limit <= pwdata[CFG_W-1:0];
                default:         cfg_reg.long_press_time   <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SHORT_LIMIT: prdata = PDATA_W'(cfg_reg.short_press_limit);
            default:         prdata = PDATA_W'(cfg_reg.long_press_time);
        endcase
    end

    // Two-register pipeline: the poll in stage one is processed when the
    // result register is free or being emptied this cycle.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg.raw_level     <= raw_level;
            s1_item_reg.confirm_level <= confirm_level;
            s1_item_reg.now_ticks     <= now_ticks;
            s1_item_reg.adc_sample    <= adc_sample;
            s1_item_reg.adc_ok        <= adc_ok;
        end
    end

    bpcs_step #(
        .ADC_BITS (ADC_BITS),
        .SAMPLE_W (SAMPLE_W)
    ) u_step (
        .ctrl             (ctrl_reg),
        .low_capture      (low_capture_reg),
        .cfg              (cfg_reg),
        .item             (s1_item_reg),
        .ctrl_next        (ctrl_next),
        .low_capture_next (low_capture_next),
        .res              (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg        <= CTRL_RESET;
            low_capture_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                ctrl_reg        <= ctrl_next;
                low_capture_reg <= low_capture_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = out_res_reg.event_res;
    assign captured_value = out_res_reg.captured_value;
    assign low_reference  = out_res_reg.low_reference;
    assign mode           = out_res_reg.mode;

    // A long press can only be pending while waiting for the low reference.
    `BPCS_ASSERT_IMP(a_long_fired_mode, ctrl_reg.long_fired,
        ctrl_reg.cal_mode == MODE_WAIT_LOW, "long press flag set outside low wait")
    // Finishing calibration always returns to idle.
    `BPCS_ASSERT_IMP(a_cal_done_idle, out_valid_reg && (event_res == EV_CAL_DONE),
        mode == MODE_CODE_IDLE, "calibration done without return to idle")
    // Entering calibration reports no capture and the low-reference wait.
    `BPCS_ASSERT_IMP(a_cal_entered, out_valid_reg && (event_res == EV_CAL_ENTERED),
        (mode == MODE_CODE_WAIT_LOW) && (captured_value == '0),
        "calibration entry with wrong mode or capture")
    // A poll in stage one is kept while the result register is stalled.
    `BPCS_ASSERT_NEXT(a_stage_hold, s1_valid_reg && out_valid_reg && !out_ready,
        s1_valid_reg, "pending poll lost during output stall")

endmodule

// ===== verif/button_press_calibration_sequencer_tb.sv =====
`timescale 1ns / 100ps

module button_press_calibration_sequencer_tb
    import bpcs_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_STALL   = 400;
    localparam int DRAIN_CYCLES = 4;

    // Mirrors the sequencer state and flags every result that disagrees with it.
    class sequencer_scoreboard;
        logic [CFG_W-1:0]  short_limit;
        logic [CFG_W-1:0]  long_limit;
        logic              last_level;
        logic [TICK_W-1:0] press_start;
        logic              long_fired;
        logic              action_done;
        logic [MODE_W-1:0] cal_mode;
        logic [ADC_W-1:0]  low_capture;
        result_t           pending_results[$];
        int                errors;

        function new();
            short_limit = SHORT_LIMIT_RST;
            long_limit  = LONG_TIME_RST;
            last_level  = 1'b1;
            press_start = '0;
            long_fired  = 1'b0;
            action_done = 1'b0;
            cal_mode    = MODE_CODE_IDLE;
            low_capture = '0;
            errors      = 0;
        endfunction

        function void set_register(input logic reg_index, input logic [PDATA_W-1:0] value);
            if (reg_index == REG_SHORT_LIMIT)
                short_limit = value[CFG_W-1:0];
            else
                long_limit = value[CFG_W-1:0];
        endfunction

        function void note_poll(input poll_t p);
            result_t           want;
            logic              level;
            logic [TICK_W-1:0] held;
            want = '0;
            want.event_res = EV_NONE;
            // A level change only counts when the debounced read agrees.
            level = (p.raw_level != last_level) ? p.confirm_level : p.raw_level;
            if (level != last_level) begin
                if (level == 1'b0) begin
                    press_start = p.now_ticks;
                    long_fired = 1'b0;
                    action_done = 1'b0;
                    want.event_res = EV_PRESSED;
                end
                else begin
                    held = p.now_ticks - press_start;
                    if (long_fired) begin
                        want.event_res = EV_AFTER_LONG;
                    end
                    else if (cal_mode == MODE_CODE_IDLE) begin
                        if (!action_done && held < TICK_W'(short_limit)) begin
                            if (p.adc_ok) begin
                                want.event_res = EV_MEAN_SET;
                                want.captured_value = p.adc_sample;
                            end
                            else begin
                                want.event_res = EV_MEAN_ERR;
                            end
                            action_done = 1'b1;
                        end
                        else begin
                            want.event_res = EV_NO_ACTION;
                        end
                    end
                    else if (!action_done) begin
                        if (cal_mode == MODE_CODE_WAIT_LOW) begin
                            if (p.adc_ok) begin
                                low_capture = p.adc_sample;
                                cal_mode = MODE_CODE_WAIT_HIGH;
                                want.event_res = EV_LOW_OK;
                                want.captured_value = p.adc_sample;
                            end
                            else begin
                                want.event_res = EV_LOW_ERR;
                            end
                        end
                        else begin
                            if (p.adc_ok) begin
                                want.event_res = EV_CAL_DONE;
                                want.captured_value = p.adc_sample;
                                want.low_reference = low_capture;
                            end
                            else begin
                                want.event_res = EV_HIGH_ERR;
                            end
                            cal_mode = MODE_CODE_IDLE;
                        end
                        action_done = 1'b1;
                    end
                    else begin
                        want.event_res = EV_NO_ACTION;
                    end
                end
                last_level = level;
            end
            // The long-press check runs on every poll and overrides the press event.
            held = p.now_ticks - press_start;
            if (!level && !long_fired && cal_mode == MODE_CODE_IDLE &&
                held >= TICK_W'(long_limit)) begin
                long_fired = 1'b1;
                cal_mode = MODE_CODE_WAIT_LOW;
                want.event_res = EV_CAL_ENTERED;
                want.captured_value = '0;
                want.low_reference = '0;
            end
            want.mode = cal_mode;
            pending_results.push_back(want);
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: event_res %0d mode %0d",
                         $time, got.event_res, got.mode);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.event_res !== want.event_res) begin
                $display("%0t: event_res expected %0d, got %0d",
                         $time, want.event_res, got.event_res);
                errors++;
            end
            if (got.captured_value !== want.captured_value) begin
                $display("%0t: captured_value expected 0x%03h, got 0x%03h",
                         $time, want.captured_value, got.captured_value);
                errors++;
            end
            if (got.low_reference !== want.low_reference) begin
                $display("%0t: low_reference expected 0x%03h, got 0x%03h",
                         $time, want.low_reference, got.low_reference);
                errors++;
            end
            if (got.mode !== want.mode) begin
                $display("%0t: mode expected %0d, got %0d", $time, want.mode, got.mode);
                errors++;
            end
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]  pwdata        = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic                raw_level     = 1'b1;
    logic                confirm_level = 1'b1;
    logic [TICK_W-1:0]   now_ticks     = '0;
    logic [ADC_W-1:0]    adc_sample    = '0;
    logic                adc_ok        = 1'b0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic [EVENT_W-1:0]  event_res;
    logic [ADC_W-1:0]    captured_value;
    logic [ADC_W-1:0]    low_reference;
    logic [MODE_W-1:0]   mode;

    sequencer_scoreboard sb;
    result_t             seen;
    logic [TICK_W-1:0]   tick_now;
    int unsigned         src_idle_pct = 0;
    int unsigned         dst_idle_pct = 0;
    int unsigned         polls_sent   = 0;
    int                  stall_left   = 0;
    int                  cycle_count  = 0;
    bit                  stall_req    = 1'b0;

    button_press_calibration_sequencer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_level      (raw_level),
        .confirm_level  (confirm_level),
        .now_ticks      (now_ticks),
        .adc_sample     (adc_sample),
        .adc_ok         (adc_ok),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .captured_value (captured_value),
        .low_reference  (low_reference),
        .mode           (mode)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("button_press_calibration_sequencer_tb: FAIL");
            $finish;
        end
    end

    // Result side: check every accepted transaction, then choose next cycle's ready.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen = {event_res, captured_value, low_reference, mode};
                sb.check_result(seen);
            end
            if (stall_req)
            begin
                stall_req = 1'b0;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    function automatic logic [ADC_W-1:0] pick_sample();
        logic [ADC_W-1:0] value;
        case ($urandom_range(9))
            0:       value = '0;
            1:       value = '1;
            default: value = ADC_W'($urandom_range(4095));
        endcase
        return value;
    endfunction

    function automatic logic pick_ok();
        return ($urandom_range(4) != 0);
    endfunction

    task automatic send_poll(input logic raw, input logic confirm,
                             input logic [TICK_W-1:0] ticks,
                             input logic [ADC_W-1:0] sample, input logic ok);
        poll_t item;
        item = {raw, confirm, ticks, sample, ok};
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_valid      <= 1'b1;
        raw_level     <= raw;
        confirm_level <= confirm;
        now_ticks     <= ticks;
        adc_sample    <= sample;
        adc_ok        <= ok;
        do @(posedge clk); while (!in_ready);
        sb.note_poll(item);
        polls_sent++;
    endtask

    task automatic write_reg(input logic reg_index, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(reg_index, value);
        @(posedge clk);
    endtask

    // Stop offering polls and let every outstanding result come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic press_release(input logic [TICK_W-1:0] hold_len,
                                 input logic [ADC_W-1:0] sample, input logic ok);
        send_poll(1'b0, 1'b0, tick_now, pick_sample(), pick_ok());
        send_poll(1'b1, 1'b1, tick_now + hold_len, sample, ok);
        tick_now = tick_now + 20000;
    endtask

    // One well-formed press: optional bounce, press, up to three hold polls, release, an optional idle poll.
    task automatic run_press_cycle();
        logic [TICK_W-1:0] hold_len;
        logic [TICK_W-1:0] t_press;
        logic [TICK_W-1:0] offset;
        int unsigned       n_hold;
        int unsigned       pick;
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2: hold_len = $urandom_range(TICK_W'(sb.short_limit));
            3:       hold_len = TICK_W'(sb.short_limit) - $urandom_range(1);
            4:       hold_len = TICK_W'(sb.long_limit) - $urandom_range(1);
            5, 6:    hold_len = TICK_W'(sb.long_limit) + $urandom_range(5000);
            7, 8:    hold_len = $urandom_range(2 * TICK_W'(sb.long_limit) + 10);
            default: hold_len = $urandom;
        endcase
        n_hold = (pick >= 4) ? $urandom_range(3, 1) : $urandom_range(2);
        if ($urandom_range(5) == 0)
            send_poll(1'b0, 1'b1, tick_now, pick_sample(), pick_ok());
        t_press = tick_now;
        send_poll(1'b0, 1'b0, t_press, pick_sample(), pick_ok());
        for (int unsigned k = 1; k <= n_hold; k++)
        begin
            offset = (k == n_hold) ? hold_len : hold_len / n_hold * k;
            send_poll($urandom_range(6) == 0, 1'b0, t_press + offset,
                      pick_sample(), pick_ok());
        end
        tick_now = t_press + hold_len;
        send_poll(1'b1, 1'b1, tick_now, pick_sample(), pick_ok());
        repeat ($urandom_range(1))
        begin
            tick_now = tick_now + $urandom_range(2000, 1);
            send_poll(1'b1, 1'($urandom_range(1)), tick_now, pick_sample(), pick_ok());
        end
        tick_now = tick_now + $urandom_range(3000, 1);
    endtask

    task automatic send_noise();
        logic [TICK_W-1:0] ticks;
        ticks = ($urandom_range(3) == 0) ? $urandom : tick_now + $urandom_range(100000);
        send_poll(1'($urandom_range(1)), 1'($urandom_range(1)), ticks,
                  pick_sample(), pick_ok());
    endtask

    task automatic run_phase(input int unsigned n_polls, input logic [PDATA_W-1:0] short_val,
                             input logic [PDATA_W-1:0] long_val, input bit hold_receiver);
        int unsigned target;
        drain();
        write_reg(REG_SHORT_LIMIT, short_val);
        write_reg(REG_LONG_TIME, long_val);
        if (hold_receiver)
            stall_req = 1'b1;
        tick_now = $urandom;
        target = polls_sent + n_polls;
        while (polls_sent < target)
        begin
            if ($urandom_range(99) < 12)
                send_noise();
            else
                run_press_cycle();
        end
    endtask

    initial
    begin
        logic [TICK_W-1:0] press_at;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 14;
        dst_idle_pct = 57;

        // Directed polls under the reset limits; the first press crosses the tick wrap.
        tick_now = 32'hFFFF_FE00;
        send_poll(1'b1, 1'b1, tick_now, 12'hFFF, 1'b1);
        send_poll(1'b0, 1'b1, tick_now + 1, 12'h000, 1'b0);
        press_at = tick_now + 2;
        send_poll(1'b0, 1'b0, press_at, 12'h555, 1'b1);
        send_poll(1'b1, 1'b0, press_at + 100, 12'hAAA, 1'b1);
        send_poll(1'b1, 1'b1, press_at + 999, 12'hFFF, 1'b1);
        tick_now = press_at + 2000;
        press_release(1000, 12'h123, 1'b1);
        press_release(5, 12'h456, 1'b0);
        // Hold past the long-press time to enter calibration.
        press_at = tick_now;
        send_poll(1'b0, 1'b0, press_at, 12'h000, 1'b1);
        send_poll(1'b0, 1'b0, press_at + 4999, 12'h000, 1'b1);
        send_poll(1'b0, 1'b1, press_at + 5000, 12'hFFF, 1'b1);
        send_poll(1'b1, 1'b1, press_at + 5001, 12'hFFF, 1'b1);
        tick_now = press_at + 10000;
        press_release(10, 12'h000, 1'b0);
        press_release(10, 12'h000, 1'b1);
        press_release(10, 12'hFFF, 1'b1);
        press_at = tick_now;
        send_poll(1'b0, 1'b0, press_at, 12'h000, 1'b1);
        send_poll(1'b0, 1'b0, press_at + 5000, 12'h000, 1'b1);
        send_poll(1'b1, 1'b1, press_at + 6000, 12'h000, 1'b1);
        tick_now = press_at + 10000;
        press_release(10, 12'hFFF, 1'b1);
        press_release(10, 12'h7FF, 1'b0);

        run_phase(220, 1000, 5000, 1'b0);
        run_phase(220, 1, 1, 1'b0);

        src_idle_pct = 57;
        dst_idle_pct = 14;
        run_phase(220, 1000000, 1000000, 1'b0);
        run_phase(220, 32'h000F_FFFF, 0, 1'b0);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        // The receiver stalls at the start of this phase so the block backs up.
        run_phase(220, $urandom_range(200, 1), $urandom_range(400, 1), 1'b1);
        run_phase(200, $urandom_range(1000000, 1), $urandom_range(1000000, 1), 1'b0);

        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("button_press_calibration_sequencer_tb: PASS");
        else
            $display("button_press_calibration_sequencer_tb: FAIL");
        $finish;
    end

endmodule
